// File: hw/rtl/asod_pkg.sv
// ============================================================================
// asod_pkg - shared types and constants of the subband onset detector
// Item formats, per-band state record, configuration indices and defaults.
// ============================================================================
package asod_pkg;

    localparam int NUM_BANDS  = 8;
    localparam int BAND_W     = $clog2(NUM_BANDS);
    localparam int HIST_DEPTH = 6;
    localparam int TAU_MAX    = 1023;
    localparam int TAU_W      = $clog2(TAU_MAX + 1);
    localparam int TSINCE_W   = 17;
    localparam int LVL_W      = 48;
    localparam int E_W        = 24;
    localparam int FRAME_W    = 20;
    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int COEF_W     = 15;

    localparam logic [TSINCE_W-1:0] TSINCE_MAX = {TSINCE_W{1'b1}};

    // Register defaults
    localparam logic [15:0]       DEF_TARGET_SPACING = 16'd345;
    localparam logic [15:0]       DEF_DEAD_TIME      = 16'd128;
    localparam logic [COEF_W-1:0] DEF_OVER_FACTOR    = 15'd18022;
    localparam logic [COEF_W-1:0] DEF_FEEDBACK_GAIN  = 15'd32113;
    localparam logic [COEF_W-1:0] DEF_TAP0_GAIN      = 15'd6170;
    localparam logic [COEF_W-1:0] DEF_TAP1_GAIN      = 15'd13861;
    localparam logic [COEF_W-1:0] DEF_TAP2_GAIN      = 15'd11115;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_TARGET_SPACING = 3'd0,
        CFG_DEAD_TIME      = 3'd1,
        CFG_OVER_FACTOR    = 3'd2,
        CFG_FEEDBACK_GAIN  = 3'd3,
        CFG_TAP0_GAIN      = 3'd4,
        CFG_TAP1_GAIN      = 3'd5,
        CFG_TAP2_GAIN      = 3'd6
    } t_cfg_addr;

    typedef struct packed {
        logic [2:0]         band_index;
        logic [FRAME_W-1:0] frame_number;
        logic [E_W-1:0]     energy;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         onset_band;
        logic [FRAME_W-1:0] onset_frame;
        logic               replaces_previous;
    } t_out_item;

    typedef struct packed {
        logic [HIST_DEPTH-1:0][E_W-1:0] hist;
        logic signed [LVL_W-1:0]        level;
        logic signed [LVL_W-1:0]        thresh;
        logic [TAU_W-1:0]               tau;
        logic [TSINCE_W-1:0]            tsince;
        logic                           contact;
        logic [FRAME_W-1:0]             last_at;
        logic                           has;
    } t_band;

    localparam t_band BAND_RESET = '{
        hist:    '0,
        level:   '0,
        thresh:  '0,
        tau:     TAU_W'(1),
        tsince:  '0,
        contact: 1'b0,
        last_at: '0,
        has:     1'b0
    };

endpackage

// File: hw/rtl/adaptive_subband_onset_detector_core.sv
// ============================================================================
// adaptive_subband_onset_detector_core - per-band onset detector
// FIR + leaky IIR level, adaptive threshold and onset reporting per subband.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) takes one energy
//   sample per transaction, tagged with band and frame. Bands may be
//   interleaved in any order; a band index beyond the band count is dropped.
//   Output channel (o_out_valid / i_out_stall / o_out_data) carries one
//   transaction per detected onset (falling edge of level over threshold).
//   Configuration: i_cfg_we writes i_cfg_data to register i_cfg_addr; the user
//   must write only while the block is idle; the block does not enforce it.
// Timing:
//   One transaction per cycle sustained, any band sequence, while the input
//   is not stalled. An onset passes stage 1 and stage 2 before it is pushed
//   into the result queue, from which the output presents it.
//   Per-band state lives in an 8-entry memory (one read, one write port);
//   read at acceptance, level computed in stage 1, threshold/onset/tau in
//   stage 2, written back at the end of stage 2. Same-band items back to
//   back are served by forwarding from stage 2 and the last write.
// Reset: synchronous; all bands return to their cleared state at once
//   (per-entry valid bits, no sweep). Results go to a 4-deep queue; input is
//   stalled during reset and when the queue plus in-flight items could overflow it.
// ============================================================================
module adaptive_subband_onset_detector_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  asod_pkg::t_in_item                   i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output asod_pkg::t_out_item                  o_out_data,
    input  logic                                 i_cfg_we,
    input  logic [asod_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [asod_pkg::CFG_W-1:0]           i_cfg_data
);

    localparam int ROM_N   = 2 ** asod_pkg::TAU_W;
    localparam int FIFO_N  = 4;
    localparam int FPTR_W  = $clog2(FIFO_N);
    localparam int FCNT_W  = $clog2(FIFO_N + 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0]                     r_target_spacing;
    logic [15:0]                     r_dead_time;
    logic [asod_pkg::COEF_W-1:0]     r_over_factor;
    logic [asod_pkg::COEF_W-1:0]     r_feedback_gain;
    logic [asod_pkg::COEF_W-1:0]     r_tap0;
    logic [asod_pkg::COEF_W-1:0]     r_tap1;
    logic [asod_pkg::COEF_W-1:0]     r_tap2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_spacing <= asod_pkg::DEF_TARGET_SPACING;
            r_dead_time      <= asod_pkg::DEF_DEAD_TIME;
            r_over_factor    <= asod_pkg::DEF_OVER_FACTOR;
            r_feedback_gain  <= asod_pkg::DEF_FEEDBACK_GAIN;
            r_tap0           <= asod_pkg::DEF_TAP0_GAIN;
            r_tap1           <= asod_pkg::DEF_TAP1_GAIN;
            r_tap2           <= asod_pkg::DEF_TAP2_GAIN;
        end else if (i_cfg_we) begin
            case (asod_pkg::t_cfg_addr'(i_cfg_addr))
                asod_pkg::CFG_TARGET_SPACING: r_target_spacing <= i_cfg_data;
                asod_pkg::CFG_DEAD_TIME:      r_dead_time      <= i_cfg_data;
                asod_pkg::CFG_OVER_FACTOR:    r_over_factor    <= i_cfg_data[14:0];
                asod_pkg::CFG_FEEDBACK_GAIN:  r_feedback_gain  <= i_cfg_data[14:0];
                asod_pkg::CFG_TAP0_GAIN:      r_tap0           <= i_cfg_data[14:0];
                asod_pkg::CFG_TAP1_GAIN:      r_tap1           <= i_cfg_data[14:0];
                asod_pkg::CFG_TAP2_GAIN:      r_tap2           <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Decay ROM: exp(-1/tau) in Q0.16 from the alternating series
    // 2^60 * sum (-1/tau)^k / k!, rounded, saturated at 65535.
    // ------------------------------------------------------------------
    logic [15:0] w_decay_rom [ROM_N];

    for (genvar t = 0; t < ROM_N; t++) begin : g_rom
        localparam int unsigned T = (t == 0) ? 1 : t;
        localparam logic [63:0] K0  = 64'h1000_0000_0000_0000;
        localparam logic [63:0] K1  = K0  / 64'(T * 1);
        localparam logic [63:0] K2  = K1  / 64'(T * 2);
        localparam logic [63:0] K3  = K2  / 64'(T * 3);
        localparam logic [63:0] K4  = K3  / 64'(T * 4);
        localparam logic [63:0] K5  = K4  / 64'(T * 5);
        localparam logic [63:0] K6  = K5  / 64'(T * 6);
        localparam logic [63:0] K7  = K6  / 64'(T * 7);
        localparam logic [63:0] K8  = K7  / 64'(T * 8);
        localparam logic [63:0] K9  = K8  / 64'(T * 9);
        localparam logic [63:0] K10 = K9  / 64'(T * 10);
        localparam logic [63:0] K11 = K10 / 64'(T * 11);
        localparam logic [63:0] K12 = K11 / 64'(T * 12);
        localparam logic [63:0] K13 = K12 / 64'(T * 13);
        localparam logic [63:0] K14 = K13 / 64'(T * 14);
        localparam logic [63:0] K15 = K14 / 64'(T * 15);
        localparam logic [63:0] K16 = K15 / 64'(T * 16);
        localparam logic [63:0] K17 = K16 / 64'(T * 17);
        localparam logic [63:0] K18 = K17 / 64'(T * 18);
        localparam logic [63:0] K19 = K18 / 64'(T * 19);
        localparam logic [63:0] S = K0 - K1 + K2 - K3 + K4 - K5 + K6 - K7 + K8 - K9
                                  + K10 - K11 + K12 - K13 + K14 - K15 + K16 - K17
                                  + K18 - K19;
        localparam logic [63:0] R = (S + (64'd1 << 43)) >> 44;
        localparam logic [15:0] D = (R > 64'd65535) ? 16'hFFFF : R[15:0];
        assign w_decay_rom[t] = D;
    end

    // ------------------------------------------------------------------
    // Handshakes, per-band state memory
    // ------------------------------------------------------------------
    logic w_in_acc;
    logic w_in_range;

    asod_pkg::t_band r_mem [asod_pkg::NUM_BANDS];
    logic [asod_pkg::NUM_BANDS-1:0] r_bvalid;
    asod_pkg::t_band r_rd_data;
    logic            r_rd_vld;

    // last written entry, covers the read that collides with a write
    logic                         r_wr_valid;
    logic [asod_pkg::BAND_W-1:0]  r_wr_band;
    asod_pkg::t_band              r_wr_data;

    // stage 1
    logic                r1_valid;
    asod_pkg::t_in_item  r1_item;
    // stage 2
    logic                r2_valid;
    asod_pkg::t_in_item  r2_item;
    asod_pkg::t_band     r2_st;
    logic [15:0]         r2_decay;

    asod_pkg::t_band     w_s2_next;
    logic                w_onset;
    logic                w_rep;

    // output queue
    asod_pkg::t_out_item r_fifo [FIFO_N];
    logic [FPTR_W-1:0]   r_wptr;
    logic [FPTR_W-1:0]   r_rptr;
    logic [FCNT_W-1:0]   r_count;
    logic [FCNT_W-1:0]   n_count;
    logic                w_push;
    logic                w_pop;

    assign w_in_range = ({1'b0, i_in_data.band_index} < 4'(asod_pkg::NUM_BANDS));
    assign o_in_stall = !i_rst_n ||
                        ((5'(r_count) + 5'(r1_valid) + 5'(r2_valid)) >= 5'(FIFO_N));
    assign w_in_acc   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_in_data.band_index[asod_pkg::BAND_W-1:0]];
        if (r2_valid) begin
            r_mem[r2_item.band_index[asod_pkg::BAND_W-1:0]] <= w_s2_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bvalid   <= '0;
            r_rd_vld   <= 1'b0;
            r_wr_valid <= 1'b0;
        end else begin
            r_rd_vld <= r_bvalid[i_in_data.band_index[asod_pkg::BAND_W-1:0]];
            if (r2_valid) begin
                r_bvalid[r2_item.band_index[asod_pkg::BAND_W-1:0]] <= 1'b1;
                r_wr_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r2_valid) begin
            r_wr_band <= r2_item.band_index[asod_pkg::BAND_W-1:0];
            r_wr_data <= w_s2_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: forward band state, FIR + IIR level, history shift
    // ------------------------------------------------------------------
    asod_pkg::t_band          w_s1_old;
    asod_pkg::t_band          w_s1_new;
    logic signed [24:0]       w_d0, w_d1, w_d2;
    logic signed [42:0]       w_fir;
    logic signed [63:0]       w_fbp;
    logic signed [49:0]       w_lvl_sum;

    function automatic logic signed [47:0] sat_lvl(input logic signed [49:0] v);
        logic signed [49:0] hi;
        logic signed [49:0] lo;
        hi = 50'sh0_7FFF_FFFF_FFFF;
        lo = -hi - 50'sd1;
        if (v > hi) begin
            sat_lvl = hi[47:0];
        end else if (v < lo) begin
            sat_lvl = lo[47:0];
        end else begin
            sat_lvl = v[47:0];
        end
    endfunction

    always_comb begin
        if (r2_valid && (r2_item.band_index == r1_item.band_index)) begin
            w_s1_old = w_s2_next;
        end else if (r_wr_valid &&
                     (r_wr_band == r1_item.band_index[asod_pkg::BAND_W-1:0])) begin
            w_s1_old = r_wr_data;
        end else if (r_rd_vld) begin
            w_s1_old = r_rd_data;
        end else begin
            w_s1_old = asod_pkg::BAND_RESET;
        end
        // frame zero restarts the band, threshold starts at the energy
        if (r1_item.frame_number == '0) begin
            w_s1_old        = asod_pkg::BAND_RESET;
            w_s1_old.thresh = {9'd0, r1_item.energy, 15'd0};
        end

        w_d0 = $signed({1'b0, r1_item.energy})     - $signed({1'b0, w_s1_old.hist[5]});
        w_d1 = $signed({1'b0, w_s1_old.hist[0]})   - $signed({1'b0, w_s1_old.hist[4]});
        w_d2 = $signed({1'b0, w_s1_old.hist[1]})   - $signed({1'b0, w_s1_old.hist[3]});
        if (r1_item.frame_number >= asod_pkg::FRAME_W'(asod_pkg::HIST_DEPTH)) begin
            w_fir = 43'($signed({1'b0, r_tap0}) * w_d0)
                  + 43'($signed({1'b0, r_tap1}) * w_d1)
                  + 43'($signed({1'b0, r_tap2}) * w_d2);
        end else begin
            w_fir = '0;
        end

        w_fbp     = w_s1_old.level * $signed({1'b0, r_feedback_gain});
        w_lvl_sum = 50'(w_fir) + 50'((w_fbp + 64'sd16384) >>> 15);

        w_s1_new       = w_s1_old;
        w_s1_new.level = sat_lvl(w_lvl_sum);
        w_s1_new.hist  = {w_s1_old.hist[4:0], r1_item.energy};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else begin
            r1_valid <= w_in_acc && w_in_range;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r1_item <= i_in_data;
        end
        r2_item  <= r1_item;
        r2_st    <= w_s1_new;
        r2_decay <= w_decay_rom[w_s1_old.tau];
    end

    // ------------------------------------------------------------------
    // Stage 2: contact, threshold update, onset, frame counter, tau
    // ------------------------------------------------------------------
    logic                          w_contact;
    logic signed [63:0]            w_pc;
    logic signed [64:0]            w_pd;
    logic [asod_pkg::TSINCE_W-1:0] w_ts0;
    logic [asod_pkg::TSINCE_W-1:0] w_ts1;
    logic signed [21:0]            w_edge;

    always_comb begin
        w_contact = r2_st.level > r2_st.thresh;
        w_pc = r2_st.level * $signed({1'b0, r_over_factor});
        w_pd = r2_st.thresh * $signed({1'b0, r2_decay});

        w_s2_next         = r2_st;
        w_s2_next.contact = w_contact;
        if (w_contact) begin
            w_s2_next.thresh = sat_lvl(50'((w_pc + 64'sd8192) >>> 14));
        end else begin
            w_s2_next.thresh = sat_lvl(50'((w_pd + 65'sd32768) >>> 16));
        end

        w_onset = !w_contact && r2_st.contact;
        w_edge  = $signed({2'b00, r2_item.frame_number}) - $signed({6'd0, r_dead_time});
        w_rep   = r2_st.has && ($signed({2'b00, r2_st.last_at}) > w_edge);

        w_ts0 = r2_st.tsince;
        if (w_onset) begin
            w_s2_next.last_at = r2_item.frame_number;
            w_s2_next.has     = 1'b1;
            w_ts0             = '0;
        end
        w_ts1 = (w_ts0 < asod_pkg::TSINCE_MAX) ? w_ts0 + 1'b1 : w_ts0;
        w_s2_next.tsince = w_ts1;

        if (w_ts1 > {1'b0, r_target_spacing}) begin
            w_s2_next.tau = (r2_st.tau > asod_pkg::TAU_W'(1)) ?
                            r2_st.tau - 1'b1 : asod_pkg::TAU_W'(1);
        end else if (r2_st.tau < asod_pkg::TAU_W'(asod_pkg::TAU_MAX)) begin
            w_s2_next.tau = r2_st.tau + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------
    assign w_push      = r2_valid && w_onset;
    assign o_out_valid = (r_count != '0);
    assign w_pop       = o_out_valid && !i_out_stall;
    assign o_out_data  = r_fifo[r_rptr];

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_push && w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wptr] <= '{onset_band:        r2_item.band_index,
                                onset_frame:       r2_item.frame_number,
                                replaces_previous: w_rep};
        end
    end

endmodule

// File: hw/rtl/asod_checker.sv
// ============================================================================
// asod_port_checker - port-level checks of the onset detector
// Output hold under stall, reset state and result latency bound.
// ============================================================================
module asod_port_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input asod_pkg::t_out_item  o_out_data
);

    logic w_acc;
    assign w_acc = i_in_valid && !o_in_stall;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result withdrawn under stall");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("result changed under stall");

    a_rst_empty: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_out_valid)
        else $error("result pending straight after reset");

    // result queue empty, nothing in stage 1 or stage 2: no new result next edge
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid && !$past(w_acc, 1) && !$past(w_acc, 2) |=> !o_out_valid)
        else $error("result without a matching input transaction");

endmodule

bind adaptive_subband_onset_detector_core asod_port_checker u_asod_checker (.*);

// File: sim/asod_checker.sv
// ----------------------------------------------------------------------------
// asod_checker - onset prediction and comparison for the subband detector
// Watches both channels and the register port, works out each band's level,
// threshold and onset, and compares every output transaction in order.
// ----------------------------------------------------------------------------
module asod_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  asod_pkg::t_in_item              i_in_data,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  asod_pkg::t_out_item             i_out_data,
    input  logic                            i_cfg_we,
    input  logic [asod_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [asod_pkg::CFG_W-1:0]      i_cfg_data,
    output int                              o_failures,
    output int                              o_onsets,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import asod_pkg::*;

    localparam longint LEVEL_TOP = 64'sd140737488355327;
    localparam longint LEVEL_BOT = -LEVEL_TOP - 1;
    localparam int     SINCE_TOP = 131071;

    // per-band state
    logic [E_W-1:0] hist_q [NUM_BANDS][HIST_DEPTH];
    longint         level_q [NUM_BANDS];
    longint         thresh_q [NUM_BANDS];
    int             tau_q [NUM_BANDS];
    int             since_q [NUM_BANDS];
    bit             contact_q [NUM_BANDS];
    int             last_at_q [NUM_BANDS];
    bit             has_q [NUM_BANDS];

    // registers
    int spacing_r, dead_r, over_r, fbk_r;
    int tap_r [3];

    int        decay_lut [TAU_MAX+1];
    t_out_item onset_queue [$];

    // exp(-1/tau) in Q0.16 by alternating series
    function automatic int decay_factor(int tau);
        longint unsigned term, sum, r;
        term = 64'd1 << 60;
        sum  = term;
        if (tau == 0) tau = 1;
        for (int k = 1; k < 64 && term != 0; k++) begin
            term = term / (longint'(tau) * k);
            if (k % 2) sum = sum - term;
            else sum = sum + term;
        end
        r = (sum + (64'd1 << 43)) >> 44;
        return (r > 65535) ? 65535 : int'(r);
    endfunction

    function automatic longint clamp48(longint v);
        if (v > LEVEL_TOP) return LEVEL_TOP;
        if (v < LEVEL_BOT) return LEVEL_BOT;
        return v;
    endfunction

    // round to nearest, ties up
    function automatic longint round_down(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic void clear_band(int b);
        for (int i = 0; i < HIST_DEPTH; i++) hist_q[b][i] = '0;
        level_q[b] = 0; thresh_q[b] = 0; tau_q[b] = 1; since_q[b] = 0;
        contact_q[b] = 0; last_at_q[b] = 0; has_q[b] = 0;
    endfunction

    function automatic void set_defaults();
        spacing_r = DEF_TARGET_SPACING; dead_r = DEF_DEAD_TIME;
        over_r = DEF_OVER_FACTOR; fbk_r = DEF_FEEDBACK_GAIN;
        tap_r[0] = DEF_TAP0_GAIN; tap_r[1] = DEF_TAP1_GAIN; tap_r[2] = DEF_TAP2_GAIN;
    endfunction

    function automatic void apply_reg(logic [CFG_ADDR_W-1:0] a, logic [CFG_W-1:0] d);
        case (a)
            CFG_TARGET_SPACING: spacing_r = d;
            CFG_DEAD_TIME:      dead_r = d;
            CFG_OVER_FACTOR:    over_r = d[COEF_W-1:0];
            CFG_FEEDBACK_GAIN:  fbk_r = d[COEF_W-1:0];
            CFG_TAP0_GAIN:      tap_r[0] = d[COEF_W-1:0];
            CFG_TAP1_GAIN:      tap_r[1] = d[COEF_W-1:0];
            CFG_TAP2_GAIN:      tap_r[2] = d[COEF_W-1:0];
            default: ;
        endcase
    endfunction

    // one energy sample through its band; queues an onset if one falls here
    function automatic void advance_band(t_in_item it);
        int        b;
        longint    e, fir, xn;
        bit        touch;
        t_out_item o;
        b = it.band_index;
        e = it.energy;
        fir = 0;
        if (b >= NUM_BANDS) return;
        if (it.frame_number == 0) begin
            clear_band(b);
            thresh_q[b] = e <<< 15;
        end
        if (it.frame_number >= HIST_DEPTH) begin
            fir += longint'(tap_r[0]) * (e - longint'(hist_q[b][5]));
            fir += longint'(tap_r[1]) * (longint'(hist_q[b][0]) - longint'(hist_q[b][4]));
            fir += longint'(tap_r[2]) * (longint'(hist_q[b][1]) - longint'(hist_q[b][3]));
        end
        xn = clamp48(fir + round_down(level_q[b] * fbk_r, 15));
        level_q[b] = xn;
        touch = xn > thresh_q[b];
        if (touch)
            thresh_q[b] = clamp48(round_down(xn * over_r, 14));
        else
            thresh_q[b] = clamp48(round_down(thresh_q[b] * decay_lut[tau_q[b]], 16));
        // falling edge of contact is the onset
        if (!touch && contact_q[b]) begin
            o.onset_band = it.band_index;
            o.onset_frame = it.frame_number;
            o.replaces_previous = has_q[b] &&
                (longint'(last_at_q[b]) > longint'(it.frame_number) - dead_r);
            onset_queue.push_back(o);
            last_at_q[b] = it.frame_number;
            has_q[b] = 1;
            since_q[b] = 0;
        end
        if (since_q[b] < SINCE_TOP) since_q[b]++;
        if (since_q[b] > spacing_r) begin
            if (tau_q[b] > 1) tau_q[b]--;
        end else if (tau_q[b] < TAU_MAX) begin
            tau_q[b]++;
        end
        contact_q[b] = touch;
        for (int i = HIST_DEPTH - 1; i > 0; i--) hist_q[b][i] = hist_q[b][i-1];
        hist_q[b][0] = it.energy;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        o_failures++;
    endtask

    initial begin
        for (int t = 0; t <= TAU_MAX; t++) decay_lut[t] = decay_factor(t);
        o_failures = 0;
        o_onsets = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            for (int b = 0; b < NUM_BANDS; b++) clear_band(b);
            set_defaults();
            onset_queue.delete();
        end else begin
            // results first: a transaction taken now cannot yield one this edge
            if (i_out_valid && !i_out_stall) begin
                o_onsets++;
                if (onset_queue.size() == 0) begin
                    report_mismatch("unexpected onset, frame", i_out_data.onset_frame, -1);
                end else begin
                    want = onset_queue.pop_front();
                    if (i_out_data.onset_band !== want.onset_band)
                        report_mismatch("onset_band", i_out_data.onset_band, want.onset_band);
                    if (i_out_data.onset_frame !== want.onset_frame)
                        report_mismatch("onset_frame", i_out_data.onset_frame,
                                        want.onset_frame);
                    if (i_out_data.replaces_previous !== want.replaces_previous)
                        report_mismatch("replaces_previous", i_out_data.replaces_previous,
                                        want.replaces_previous);
                end
            end
            if (i_in_valid && !i_in_stall) advance_band(i_in_data);
            if (i_cfg_we) apply_reg(i_cfg_addr, i_cfg_data);
        end
        o_pending = onset_queue.size();
    end

    final begin
        if (onset_queue.size() != 0)
            $display("%0d onsets never arrived", onset_queue.size());
    end

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - testbench for the adaptive subband onset detector
// Drives energy samples band by band under random idling on both channels,
// steps through several register settings, and leaves all checking to
// asod_checker.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import asod_pkg::*;

    // index past the register list, written to show it is ignored
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 3'd7;
    localparam int ITEMS_TARGET = 550;
    localparam int QUIET_TAIL   = 80;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    t_in_item              in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]      cfg_data = '0;

    int failures, onsets, pending;
    int sent = 0;
    int phases = 0;
    bit quiet = 1'b0;   // no idling on either side once set
    int frame_of [NUM_BANDS];

    always #6 i_clk = ~i_clk;

    adaptive_subband_onset_detector_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_data  (cfg_data)
    );

    asod_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_data  (cfg_data),
        .o_failures  (failures),
        .o_onsets    (onsets),
        .o_pending   (pending)
    );

    // Receiver back-pressure: stall bursts of random length between open
    // stretches of random length, silenced in the tail.
    initial begin
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 99) < 20) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 18) - 1) @(negedge i_clk);
                @(negedge i_clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Present one transaction at the falling edge and hold it until taken.
    // Valid stays high into the next call unless a sender gap burst lowers it.
    task automatic send_sample(logic [2:0] band, logic [FRAME_W-1:0] frame,
                               logic [E_W-1:0] energy);
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_data <= '{band_index: band, frame_number: frame, energy: energy};
        do @(posedge i_clk); while (in_stall);
        sent++;
        // sender gap burst
        if (!quiet && $urandom_range(0, 99) < 20) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18) - 1) @(negedge i_clk);
        end
    endtask

    // Lower valid and wait until every predicted onset has been seen, plus
    // the pipeline depth for items that produce none.
    task automatic drain();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_regs(int spacing, int dead, int over, int fbk,
                              int t0, int t1, int t2);
        logic [CFG_ADDR_W-1:0] addr [8];
        int                    val [8];
        addr = '{CFG_TARGET_SPACING, CFG_DEAD_TIME, CFG_OVER_FACTOR, CFG_FEEDBACK_GAIN,
                 CFG_TAP0_GAIN, CFG_TAP1_GAIN, CFG_TAP2_GAIN, CFG_SPARE};
        val = '{spacing, dead, over, fbk, t0, t1, t2, $urandom_range(0, 65535)};
        for (int i = 0; i < 8; i++) begin
            @(negedge i_clk);
            cfg_we <= 1'b1;
            cfg_addr <= addr[i];
            cfg_data <= CFG_W'(val[i]);
        end
        @(negedge i_clk);
        cfg_we <= 1'b0;
        phases++;
        // every band starts its next sequence from frame zero
        foreach (frame_of[b]) frame_of[b] = 0;
    endtask

    // Mostly well-formed per-band frame sequences with quiet energies and
    // occasional bursts (these make onsets); the rest is unordered noise.
    task automatic random_samples(int count, bit with_tail);
        int               band, n;
        logic [E_W-1:0]   energy;
        n = 0;
        while (n < count) begin
            // last stretch runs with no idling on either side
            if (with_tail && n >= count - QUIET_TAIL)
                quiet = 1'b1;
            band = $urandom_range(0, NUM_BANDS - 1);
            if ($urandom_range(0, 99) < 85) begin
                if ($urandom_range(0, 99) < 2) frame_of[band] = 0;
                if ($urandom_range(0, 99) < 12)
                    energy = E_W'($urandom_range(24'h100000, 24'hFFFFFF));
                else energy = E_W'($urandom_range(0, 24'h3FFF));
                send_sample(3'(band), FRAME_W'(frame_of[band]), energy);
                frame_of[band] = (frame_of[band] + 1) % (1 << FRAME_W);
            end else begin
                send_sample(3'(band), FRAME_W'($urandom_range(0, (1 << FRAME_W) - 1)),
                            E_W'($urandom_range(0, (1 << E_W) - 1)));
            end
            n++;
        end
    endtask

    initial begin
        foreach (frame_of[b]) frame_of[b] = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, band restart, onset with no earlier one,
        // frames out of order
        send_sample(3'd0, 20'd0, 24'hFFFFFF);
        send_sample(3'd0, 20'd1, 24'd0);
        send_sample(3'd0, 20'hFFFFF, 24'hFFFFFF);
        send_sample(3'd0, 20'hFFFFF, 24'd0);
        send_sample(3'd7, 20'd0, 24'd0);
        for (int f = 1; f <= 8; f++) send_sample(3'd7, FRAME_W'(f), 24'd16);
        send_sample(3'd7, 20'd9, 24'hFFFFFF);
        send_sample(3'd7, 20'd10, 24'd0);
        send_sample(3'd7, 20'd11, 24'd0);
        send_sample(3'd7, 20'd3, 24'd0);
        send_sample(3'd7, 20'd12, 24'd0);
        send_sample(3'd7, 20'd13, 24'hFFFFFF);
        send_sample(3'd7, 20'd14, 24'd0);
        send_sample(3'd7, 20'd15, 24'd0);
        send_sample(3'd7, 20'd16, 24'd0);

        random_samples(140, 1'b0);
        // hold off until the block has emptied
        drain();

        write_regs(0, 65535, 16384, 32767, 32767, 32767, 32767);
        random_samples(120, 1'b0);
        drain();
        write_regs(65535, 0, 32767, 0, 0, 32767, 0);
        random_samples(100, 1'b0);
        drain();
        write_regs($urandom_range(0, 400), $urandom_range(0, 300),
                   $urandom_range(16384, 32767), $urandom_range(30000, 32767),
                   $urandom_range(0, 32767), $urandom_range(0, 32767),
                   $urandom_range(0, 32767));
        random_samples(ITEMS_TARGET - sent, 1'b1);

        quiet = 1'b1;
        drain();
        $display("covered %0d samples over %0d register settings, %0d onsets seen",
                 sent, phases + 1, onsets);
        if (failures == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout with %0d onsets outstanding", pending);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
